// File: design/swde_pkg.sv
// Shared types and constants for the square-wave duty estimator.
// Used by every module of the block; depends on nothing.
package swde_pkg;

  localparam int SMP_W  = 12;
  localparam int FAC_W  = 9;
  localparam int DUTY_W = 17;
  localparam int HC_W   = 13;
  localparam int MEAN_W = SMP_W + 8;
  localparam int VAR_W  = 38;
  localparam int ROOT_W = VAR_W / 2;
  localparam int THR_W  = SMP_W + 16 + 1;

  localparam logic [FAC_W-1:0] FAC_RST = 9'd205;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_q16;
    logic [HC_W-1:0]   high_count;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic op;
  } itu_req_t;

endpackage

// File: design/square_wave_duty_estimator_core.sv
// Square-wave duty estimator: top level with the sequencer and accumulators.
// Depends on swde_pkg, swde_store, swde_itu and swde_sqrt.
//
// Usage: samples arrive on the in_ channel, one beat per sample, the final
// sample of a block flagged by in_data.last. Loading takes one beat a cycle.
// Beyond MAX_SAMPLES samples, further samples are dropped; the flag still ends
// the block. After the flagged beat the block computes mean and deviation,
// forms the threshold from cfg threshold factor, counts the samples above it
// and puts one beat on the out_ channel. in_stall stays high during that work.
// The work is six passes of the shared bit-serial multiply/divide unit of
// width W = 2*12 + 2*ceil(log2(MAX_SAMPLES+1)) + 16 (66 at the default),
// 19 square-root steps and one memory read per stored sample.
// A new block loads only once the last block's result has left S_EMIT.
// Reset clears the sums, the count and the output valid, and sets the factor
// to 205; sample memory is left as it is. While out_stall holds a result, the
// next block still loads; its own result waits until the output register frees.
module square_wave_duty_estimator_core #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  swde_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output swde_pkg::out_beat_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [swde_pkg::FAC_W-1:0]      cfg_wr_data
);
  import swde_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int ADR_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SMP_W + CNT_W;
  localparam int SQ_W  = 2 * SMP_W + CNT_W;
  localparam int D_W   = SQ_W + CNT_W;
  localparam int W     = D_W + 16;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MEAN  = 4'd1;
  localparam logic [3:0] S_MULN  = 4'd2;
  localparam logic [3:0] S_MULS  = 4'd3;
  localparam logic [3:0] S_QDIV  = 4'd4;
  localparam logic [3:0] S_VDIV  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_COUNT = 4'd7;
  localparam logic [3:0] S_DUTY  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic              go_r, go_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [FAC_W-1:0]  factor_r;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [W-1:0]      work_r, work_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  above_r, above_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  logic [2*SMP_W-1:0]      smp_sq;
  logic [ROOT_W+FAC_W-1:0] std_prod;
  logic                    wr_en, rd_en, above;
  logic [SMP_W-1:0]        rd_data;
  itu_req_t                itu_req;
  logic [W-1:0]            itu_opa, itu_opb, itu_res;
  logic                    itu_busy, itu_done;
  logic                    sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;
  logic                    emit_go;

  assign smp_sq   = in_data.sample * in_data.sample;
  assign std_prod = sqrt_root * factor_r;
  assign above    = THR_W'({rd_data, 16'b0}) > thr_r;
  assign emit_go  = !out_valid_r || !out_stall;

  swde_store #(
    .DEPTH (MAX_SAMPLES),
    .ADR_W (ADR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (n_r[ADR_W-1:0]),
    .wr_data (in_data.sample),
    .rd_en   (rd_en),
    .rd_addr (idx_r[ADR_W-1:0]),
    .rd_data (rd_data)
  );

  swde_itu #(
    .W (W)
  ) u_itu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (itu_req),
    .opa   (itu_opa),
    .opb   (itu_opb),
    .busy  (itu_busy),
    .done  (itu_done),
    .res   (itu_res)
  );

  swde_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v     (itu_res[VAR_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = go_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    mean_nxt      = mean_r;
    work_nxt      = work_r;
    thr_nxt       = thr_r;
    idx_nxt       = idx_r;
    above_nxt     = above_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    sqrt_start    = 1'b0;
    itu_req.start = 1'b0;
    itu_req.op    = OP_DIV;
    itu_opa       = W'(n_r);
    itu_opb       = '0;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (n_r != CNT_W'(MAX_SAMPLES)) begin
            wr_en   = 1'b1;
            sum_nxt = sum_r + SUM_W'(in_data.sample);
            sq_nxt  = sq_r + SQ_W'(smp_sq);
            n_nxt   = n_r + 1'b1;
          end
          if (in_data.last) begin
            state_nxt = S_MEAN;
            go_nxt    = 1'b1;
          end
        end
      end
      S_MEAN: begin
        itu_req.start = go_r;
        itu_opb       = W'({sum_r, 8'b0});
        go_nxt        = 1'b0;
        if (itu_done) begin
          mean_nxt  = itu_res[MEAN_W-1:0];
          state_nxt = S_MULN;
          go_nxt    = 1'b1;
        end
      end
      S_MULN: begin
        itu_req.start = go_r;
        itu_req.op    = OP_MUL;
        itu_opa       = W'(sq_r);
        itu_opb       = W'(n_r);
        go_nxt        = 1'b0;
        if (itu_done) begin
          work_nxt  = itu_res;
          state_nxt = S_MULS;
          go_nxt    = 1'b1;
        end
      end
      S_MULS: begin
        itu_req.start = go_r;
        itu_req.op    = OP_MUL;
        itu_opa       = W'(sum_r);
        itu_opb       = W'(sum_r);
        go_nxt        = 1'b0;
        if (itu_done) begin
          work_nxt  = work_r - itu_res;
          state_nxt = S_QDIV;
          go_nxt    = 1'b1;
        end
      end
      S_QDIV: begin
        itu_req.start = go_r;
        itu_opb       = work_r << 16;
        go_nxt        = 1'b0;
        if (itu_done) begin
          work_nxt  = itu_res;
          state_nxt = S_VDIV;
          go_nxt    = 1'b1;
        end
      end
      S_VDIV: begin
        itu_req.start = go_r;
        itu_opb       = work_r;
        go_nxt        = 1'b0;
        if (itu_done) begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          thr_nxt   = THR_W'({mean_r, 8'b0}) + THR_W'(std_prod);
          idx_nxt   = '0;
          above_nxt = '0;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        if (idx_r != n_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        pend_nxt = rd_en;
        if (pend_r && above) begin
          above_nxt = above_r + 1'b1;
        end
        if (idx_r == n_r && !pend_r) begin
          state_nxt = S_DUTY;
          go_nxt    = 1'b1;
        end
      end
      S_DUTY: begin
        itu_req.start = go_r;
        itu_opb       = W'({above_r, 16'b0});
        go_nxt        = 1'b0;
        if (itu_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.duty_q16   = itu_res[DUTY_W-1:0];
          out_data_nxt.high_count = HC_W'(above_r);
          sum_nxt                 = '0;
          sq_nxt                  = '0;
          n_nxt                   = '0;
          state_nxt               = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      go_r        <= 1'b0;
      n_r         <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      factor_r    <= FAC_RST;
      idx_r       <= '0;
      above_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      n_r         <= n_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      idx_r       <= idx_nxt;
      above_r     <= above_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        factor_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mean_r     <= mean_nxt;
    work_r     <= work_nxt;
    thr_r      <= thr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_above_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> above_r <= n_r)
    else $error("high count exceeds block length");

  a_itu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    itu_req.start |-> !itu_busy)
    else $error("shared unit started while busy");

  a_sqrt_state: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == S_SQRT)
    else $error("root finished outside its step");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_go) |=> (out_valid_r && n_r == '0 && state_r == S_LOAD))
    else $error("result beat not issued on emit");

endmodule

// File: design/swde_store.sv
// Sample memory: one write port, one read port with registered read data.
// Depends on swde_pkg for the sample width.
module swde_store #(
  parameter int DEPTH = 4096,
  parameter int ADR_W = 12
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADR_W-1:0]            wr_addr,
  input  logic [swde_pkg::SMP_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADR_W-1:0]            rd_addr,
  output logic [swde_pkg::SMP_W-1:0]  rd_data
);
  import swde_pkg::*;

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/swde_itu.sv
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit a cycle.
// Depends on swde_pkg for the request struct and operation codes.
module swde_itu #(
  parameter int W = 66
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swde_pkg::itu_req_t req,
  input  logic [W-1:0]       opa,
  input  logic [W-1:0]       opb,
  output logic               busy,
  output logic               done,
  output logic [W-1:0]       res
);
  import swde_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_r, b_r, acc_r;
  logic [W-1:0]  b_nxt, acc_nxt;
  logic [CW-1:0] cnt_r;
  logic          op_r, busy_r, done_r;
  logic [W:0]    rem_sh;
  logic          ge;

  assign rem_sh = {acc_r, b_r[W-1]};
  assign ge     = rem_sh >= {1'b0, a_r};

  always_comb begin
    if (op_r == OP_DIV) begin
      acc_nxt = ge ? W'(rem_sh - {1'b0, a_r}) : rem_sh[W-1:0];
      b_nxt   = {b_r[W-2:0], ge};
    end else begin
      acc_nxt = (acc_r << 1) + (b_r[W-1] ? a_r : '0);
      b_nxt   = b_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
      op_r  <= req.op;
    end else if (busy_r) begin
      b_r   <= b_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = (op_r == OP_DIV) ? b_r : acc_r;

endmodule

// File: design/swde_sqrt.sv
// Truncating integer square root, one result bit a cycle.
// Depends on swde_pkg for the operand and root widths.
module swde_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [swde_pkg::VAR_W-1:0]  v,
  output logic                        done,
  output logic [swde_pkg::ROOT_W-1:0] root
);
  import swde_pkg::*;

  logic [VAR_W-1:0] v_r, res_r, bit_r, trial;
  logic             busy_r, done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v;
      res_r <= '0;
      bit_r <= VAR_W'(1) << (VAR_W - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule
